>>> hw/rtl/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg: shared types and constants of the k-sorted stream sorter
// Holds the window size, the field widths and the structs that pass
// between the top level, the cell chain and the cells.
// ----------------------------------------------------------------------------
package kss_pkg;

   localparam int WINDOW_CAPACITY = 32;
   localparam int DATA_W          = 32;
   localparam int K_W             = 5;
   localparam int CNT_W           = $clog2(WINDOW_CAPACITY + 1);
   localparam int LIM_W           = (CNT_W > K_W + 1) ? CNT_W : K_W + 1;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic                     pop;    // shift the row one place toward the head
      logic                     ins;    // insert value at its sorted place
      logic signed [DATA_W-1:0] value;
   } kss_ctrl_type;

   // What a cell shows to its neighbors
   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     valid;
      logic                     le;     // own value is not greater than the new value
   } kss_cell_type;

endpackage

>>> hw/rtl/kss_stream_if.sv
// ----------------------------------------------------------------------------
// kss_req_if / kss_rsp_if: valid/ready channels of the sorter
// A transaction moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface kss_req_if;
   import kss_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic                     end_of_stream;

   modport source (output valid, output value, output end_of_stream, input ready);
   modport sink   (input valid, input value, input end_of_stream, output ready);
endinterface

interface kss_rsp_if;
   import kss_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sorted_value;
   logic                     final_res;

   modport source (output valid, output sorted_value, output final_res, input ready);
   modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

>>> hw/rtl/k_sorted_stream_sorter.sv
// ----------------------------------------------------------------------------
// k_sorted_stream_sorter: sorter for streams with bounded displacement
// Keeps up to min(k+1, WINDOW_CAPACITY) values sorted in a cell chain, emits
// the minimum once the window is full and drains the window at end of stream.
// ----------------------------------------------------------------------------
//  channel    dir  handshake     payload
//  req_chan   in   valid/ready   value[31:0] signed, end_of_stream
//  rsp_chan   out  valid/ready   sorted_value[31:0] signed, final_res
//  csr_*      in   wr_en only    wr_data[4:0] = k
//
//  One request transaction per cycle while streaming and the output is not
//  stalled; pop and insert happen together in the cell chain.
//  After end_of_stream the drain emits one result per cycle while the output
//  is not stalled, and no request is taken until the window is empty.
//  The output register decouples the sides: a request is taken while the
//  held result is taken in the same cycle; a stalled result stalls requests.
//  Reset (synchronous) empties the window and sets k to zero.
// ----------------------------------------------------------------------------
module k_sorted_stream_sorter
   import kss_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [K_W-1:0]  csr_wr_data,
   kss_req_if.sink         req_chan,
   kss_rsp_if.source       rsp_chan
);

   localparam logic ST_RUN   = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                     state_ff, state_in;
   logic [K_W-1:0]           k_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_val_ff, out_val_in;
   logic                     out_final_ff, out_final_in;

   logic                     slot_free, accept, win_full;
   logic [LIM_W-1:0]         limit;
   logic signed [DATA_W-1:0] head_value;
   kss_ctrl_type             ctrl;

   assign slot_free = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_RUN) && slot_free;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      if (LIM_W'(k_ff) + LIM_W'(1) > LIM_W'(WINDOW_CAPACITY)) begin
         limit = LIM_W'(WINDOW_CAPACITY);
      end else begin
         limit = LIM_W'(k_ff) + LIM_W'(1);
      end
   end

   assign win_full = (LIM_W'(count_ff) >= limit) && (count_ff != '0);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_val_in   = out_val_ff;
      out_final_in = out_final_ff;
      ctrl         = '{pop: 1'b0, ins: 1'b0, value: req_chan.value};

      unique case (state_ff)
         ST_RUN: begin
            if (accept) begin
               ctrl.ins = 1'b1;
               if (win_full) begin
                  ctrl.pop     = 1'b1;
                  out_valid_in = 1'b1;
                  out_val_in   = head_value;
                  out_final_in = 1'b0;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_chan.end_of_stream) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (count_ff == '0) begin
               state_in = ST_RUN;
            end else if (slot_free) begin
               // advance the head into the output register
               ctrl.pop     = 1'b1;
               out_valid_in = 1'b1;
               out_val_in   = head_value;
               out_final_in = (count_ff == CNT_W'(1));
               count_in     = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   kss_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .head_value (head_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            k_ff <= csr_wr_data;
         end
      end
      out_val_ff   <= out_val_in;
      out_final_ff <= out_final_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.sorted_value = out_val_ff;
   assign rsp_chan.final_res    = out_final_ff;

endmodule

>>> hw/rtl/kss_cell.sv
// ----------------------------------------------------------------------------
// kss_cell: one slot of the sorted window
// Holds one value and its valid bit. Each cycle it may take its right
// neighbor's value (pop), keep its own, take the new value or take its left
// neighbor's value, so the row stays sorted ascending from the head.
// ----------------------------------------------------------------------------
module kss_cell
   import kss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         at_head,
   input  kss_ctrl_type ctrl,
   input  kss_cell_type left_nb,
   input  kss_cell_type right_nb,
   output kss_cell_type cell_out
);

   logic signed [DATA_W-1:0] val_ff, val_in;
   logic                     valid_ff, valid_in;
   logic                     le;

   // view after the optional pop: own slot and left slot
   logic signed [DATA_W-1:0] t_val, t_left_val;
   logic                     t_valid, t_le, t_left_valid, t_left_le;

   assign le = valid_ff && !(ctrl.value < val_ff);

   assign cell_out = '{val: val_ff, valid: valid_ff, le: le};

   always_comb begin
      if (ctrl.pop) begin
         t_val   = right_nb.val;
         t_valid = right_nb.valid;
         t_le    = right_nb.le;
      end else begin
         t_val   = val_ff;
         t_valid = valid_ff;
         t_le    = le;
      end

      // past the head, the slot to the left after a pop holds this cell's own value
      if (ctrl.pop && !at_head) begin
         t_left_val   = val_ff;
         t_left_valid = valid_ff;
         t_left_le    = le;
      end else begin
         t_left_val   = left_nb.val;
         t_left_valid = left_nb.valid;
         t_left_le    = left_nb.le;
      end

      if (ctrl.ins) begin
         if (t_le) begin
            val_in = t_val;
         end else if (t_left_le) begin
            val_in = ctrl.value;
         end else begin
            val_in = t_left_val;
         end
         valid_in = t_valid | t_left_valid;
      end else begin
         val_in   = t_val;
         valid_in = t_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      val_ff <= val_in;
   end

endmodule

>>> hw/rtl/kss_chain.sv
// ----------------------------------------------------------------------------
// kss_chain: row of sorting cells
// Links WINDOW_CAPACITY cells neighbor to neighbor and shows the head cell,
// which always holds the window minimum.
// ----------------------------------------------------------------------------
module kss_chain
   import kss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  kss_ctrl_type             ctrl,
   output logic signed [DATA_W-1:0] head_value
);

   kss_cell_type cells[WINDOW_CAPACITY];

   localparam kss_cell_type HEAD_EDGE = '{val: '0, valid: 1'b1, le: 1'b1};
   localparam kss_cell_type TAIL_EDGE = '{val: '0, valid: 1'b0, le: 1'b0};

   for (genvar i = 0; i < WINDOW_CAPACITY; i++) begin : g_cell
      kss_cell_type left_nb, right_nb;

      if (i == 0) begin : g_head
         assign left_nb = HEAD_EDGE;
      end else begin : g_mid_l
         assign left_nb = cells[i-1];
      end

      if (i == WINDOW_CAPACITY - 1) begin : g_tail
         assign right_nb = TAIL_EDGE;
      end else begin : g_mid_r
         assign right_nb = cells[i+1];
      end

      kss_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .at_head  (i == 0),
         .ctrl     (ctrl),
         .left_nb  (left_nb),
         .right_nb (right_nb),
         .cell_out (cells[i])
      );
   end

   assign head_value = cells[0].val;

endmodule
